// ----- hw/rtl/cgpg_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table of the cone gradient generator.
package cgpg_pkg;

	localparam int COORD_W    = 17;
	localparam int GAIN_W     = 16;
	localparam int VALUE_W    = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int ZACC_W     = 32;
	localparam int ATAN_IDX_W = 5;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_CW  = 2'd0;
	localparam mode_t MODE_ACW = 2'd1;
	localparam mode_t MODE_SYM = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ANGLE_MODE   = 2'd0;
	localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd1;
	localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd2;

	localparam logic [GAIN_W-1:0]     GAIN_RESET   = 16'd256;
	localparam logic [CFG_DATA_W-1:0] DIM_RESET    = 13'd64;
	localparam logic [VALUE_W-1:0]    VALUE_CENTRE = 24'h008000;
	localparam logic [VALUE_W-1:0]    VALUE_MAX    = 24'hFFFFFF;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [ZACC_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic [ZACC_W-1:0] r;
		case (idx)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/cone_gradient_pixel_generator_core.sv -----
// Top level of the conical gradient pixel generator.
// Usage:
//   Input channel (in_valid / in_stall): kind 0 loads centre, reference point
//   and gain and restarts the raster at column 0, row 0; kind 1 asks for the
//   next pixel in raster order. A transaction completes on a rising edge with
//   in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one transaction per pixel item,
//   none for a frame item; value is Q8.16, last_of_frame marks the frame end.
//   Config channel (cfg_valid / cfg_ready): cfg_index 0 angle mode, 1 frame
//   width, 2 frame height; cfg_ready is always high. Write only while idle.
// Back end:
//   The back end runs one CORDIC rotation step per cycle on a shared
//   adder set. A pixel passes through load, steps, multiply and output;
//   a frame item passes through load, steps and reference capture. The
//   back end takes a new item from the queue only once it is done with
//   the last one.
// Reset clears the raster, centre, reference angle, the queue and the output
// valid; gain returns to 1.0, frame size to 64x64, mode to clockwise.
// While out_stall is high the result is held; the back end finishes the next
// item and waits, the two-entry queue fills, then in_stall rises.
module cone_gradient_pixel_generator_core #(
	parameter int MAX_DIM      = 4096,
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// item input
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     kind,
	input  logic signed [cgpg_pkg::COORD_W-1:0]      center_x,
	input  logic signed [cgpg_pkg::COORD_W-1:0]      center_y,
	input  logic signed [cgpg_pkg::COORD_W-1:0]      ref_x,
	input  logic signed [cgpg_pkg::COORD_W-1:0]      ref_y,
	input  logic        [cgpg_pkg::GAIN_W-1:0]       gain,
	// result output
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic        [cgpg_pkg::VALUE_W-1:0]      value,
	output logic                                     last_of_frame,
	// register writes
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  cgpg_pkg::cfg_idx_t                       cfg_index,
	input  logic        [cgpg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cgpg_pkg::*;

	localparam int CW     = $clog2(MAX_DIM);
	// pixel position minus centre, signed
	localparam int DIFF_W = ((CW + 5 > COORD_W) ? (CW + 5) : COORD_W) + 1;
	localparam int JOB_W  = 2 + 2 * DIFF_W + GAIN_W;

	mode_t                   angle_mode_q;
	logic [CFG_DATA_W-1:0]   frame_width_q;
	logic [CFG_DATA_W-1:0]   frame_height_q;

	logic                    job_push;
	logic                    job_full;
	logic                    job_pop;
	logic                    job_valid;
	logic                    push_frame;
	logic                    push_last;
	logic signed [DIFF_W-1:0] push_dx;
	logic signed [DIFF_W-1:0] push_dy;
	logic [GAIN_W-1:0]       push_gain;
	logic [JOB_W-1:0]        push_data;
	logic [JOB_W-1:0]        pop_data;
	logic                    pop_frame;
	logic                    pop_last;
	logic signed [DIFF_W-1:0] pop_dx;
	logic signed [DIFF_W-1:0] pop_dy;
	logic [GAIN_W-1:0]       pop_gain;

	// config registers: always ready, one write per cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_mode_q   <= MODE_CW;
			frame_width_q  <= DIM_RESET;
			frame_height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ANGLE_MODE:   angle_mode_q   <= mode_t'(cfg_data[1:0]);
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cgpg_front #(
		.MAX_DIM (MAX_DIM),
		.DIFF_W  (DIFF_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.center_x     (center_x),
		.center_y     (center_y),
		.ref_x        (ref_x),
		.ref_y        (ref_y),
		.gain         (gain),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.job_full     (job_full),
		.job_push     (job_push),
		.job_frame    (push_frame),
		.job_last     (push_last),
		.job_dx       (push_dx),
		.job_dy       (push_dy),
		.job_gain     (push_gain)
	);

	assign push_data = {push_frame, push_last, push_dx, push_dy, push_gain};

	cgpg_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.wdata     (push_data),
		.full      (job_full),
		.pop       (job_pop),
		.rdata     (pop_data),
		.not_empty (job_valid)
	);

	assign {pop_frame, pop_last, pop_dx, pop_dy, pop_gain} = pop_data;

	cgpg_back #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.ANGLE_BITS   (ANGLE_BITS),
		.DIFF_W       (DIFF_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job_pop       (job_pop),
		.job_frame     (pop_frame),
		.job_last      (pop_last),
		.job_dx        (pop_dx),
		.job_dy        (pop_dy),
		.job_gain      (pop_gain),
		.angle_mode    (angle_mode_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value         (value),
		.last_of_frame (last_of_frame)
	);

endmodule

// ----- hw/rtl/cgpg_fifo.sv -----
// Small register queue between the front and back parts.
module cgpg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/cgpg_front.sv -----
// Front part: accepts items, keeps centre and raster position, builds angle jobs.
module cgpg_front #(
	parameter int MAX_DIM = 4096,
	parameter int DIFF_W  = 18
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     kind,
	input  logic signed [cgpg_pkg::COORD_W-1:0]      center_x,
	input  logic signed [cgpg_pkg::COORD_W-1:0]      center_y,
	input  logic signed [cgpg_pkg::COORD_W-1:0]      ref_x,
	input  logic signed [cgpg_pkg::COORD_W-1:0]      ref_y,
	input  logic        [cgpg_pkg::GAIN_W-1:0]       gain,
	input  logic        [cgpg_pkg::CFG_DATA_W-1:0]   frame_width,
	input  logic        [cgpg_pkg::CFG_DATA_W-1:0]   frame_height,
	input  logic                                     job_full,
	output logic                                     job_push,
	output logic                                     job_frame,
	output logic                                     job_last,
	output logic signed [DIFF_W-1:0]                 job_dx,
	output logic signed [DIFF_W-1:0]                 job_dy,
	output logic        [cgpg_pkg::GAIN_W-1:0]       job_gain
);
	import cgpg_pkg::*;

	localparam int CW  = $clog2(MAX_DIM);
	localparam int EXT = DIFF_W - COORD_W;
	localparam int PAD = DIFF_W - CW - 4;

	logic signed [COORD_W-1:0] centre_x_q;
	logic signed [COORD_W-1:0] centre_y_q;
	logic [CW-1:0]             col_q;
	logic [CW-1:0]             row_q;

	logic                      accept;
	logic [31:0]               w_lim;
	logic [31:0]               h_lim;
	logic                      end_row;
	logic                      end_frame;
	logic signed [DIFF_W-1:0]  pix_x;
	logic signed [DIFF_W-1:0]  pix_y;
	logic signed [DIFF_W-1:0]  ref_dx;
	logic signed [DIFF_W-1:0]  ref_dy;

	assign accept   = in_valid && !job_full;
	assign in_stall = job_full;

	// frame size clamped into 1..MAX_DIM
	always_comb begin
		if (frame_width == '0) begin
			w_lim = 32'd1;
		end else if (32'(frame_width) > 32'(MAX_DIM)) begin
			w_lim = 32'(MAX_DIM);
		end else begin
			w_lim = 32'(frame_width);
		end
		if (frame_height == '0) begin
			h_lim = 32'd1;
		end else if (32'(frame_height) > 32'(MAX_DIM)) begin
			h_lim = 32'(MAX_DIM);
		end else begin
			h_lim = 32'(frame_height);
		end
	end

	assign end_row   = (32'(col_q) + 32'd1) >= w_lim;
	assign end_frame = end_row && ((32'(row_q) + 32'd1) >= h_lim);

	assign pix_x  = $signed({{PAD{1'b0}}, col_q, 4'b0000})
		- $signed({{EXT{centre_x_q[COORD_W-1]}}, centre_x_q});
	assign pix_y  = $signed({{PAD{1'b0}}, row_q, 4'b0000})
		- $signed({{EXT{centre_y_q[COORD_W-1]}}, centre_y_q});
	assign ref_dx = $signed({{EXT{ref_x[COORD_W-1]}}, ref_x})
		- $signed({{EXT{center_x[COORD_W-1]}}, center_x});
	assign ref_dy = $signed({{EXT{ref_y[COORD_W-1]}}, ref_y})
		- $signed({{EXT{center_y[COORD_W-1]}}, center_y});

	assign job_push  = accept;
	assign job_frame = !kind;
	assign job_last  = kind && end_frame;
	assign job_dx    = kind ? pix_x : ref_dx;
	assign job_dy    = kind ? pix_y : ref_dy;
	assign job_gain  = gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (accept) begin
			if (!kind) begin
				centre_x_q <= center_x;
				centre_y_q <= center_y;
				col_q      <= '0;
				row_q      <= '0;
			end else if (end_frame) begin
				col_q <= '0;
				row_q <= '0;
			end else if (end_row) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/cgpg_back.sv -----
// Back part: iterative CORDIC angle, reference offset, mirror, gain, fold and output register.
module cgpg_back #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16,
	parameter int DIFF_W       = 18
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 job_valid,
	output logic                                 job_pop,
	input  logic                                 job_frame,
	input  logic                                 job_last,
	input  logic signed [DIFF_W-1:0]             job_dx,
	input  logic signed [DIFF_W-1:0]             job_dy,
	input  logic        [cgpg_pkg::GAIN_W-1:0]   job_gain,
	input  cgpg_pkg::mode_t                      angle_mode,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [cgpg_pkg::VALUE_W-1:0]  value,
	output logic                                 last_of_frame
);
	import cgpg_pkg::*;

	localparam int DW    = DIFF_W + 10;
	localparam int SW    = $clog2(CORDIC_STEPS);
	localparam int PRODW = ANGLE_BITS + 1 + GAIN_W;
	localparam int FOLDW = ANGLE_BITS + 9;
	localparam int SHW   = PRODW - (ANGLE_BITS - 8);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROT  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [SW-1:0]           step_q;
	logic signed [DW-1:0]    x_q;
	logic signed [DW-1:0]    y_q;
	logic [ZACC_W-1:0]       z_q;
	logic                    frame_q;
	logic                    last_q;
	logic                    zero_q;
	logic [ANGLE_BITS-1:0]   ref_q;
	logic [GAIN_W-1:0]       gain_q;
	logic [PRODW-1:0]        prod_q;
	logic                    out_valid_q;
	logic [VALUE_W-1:0]      value_q;
	logic                    last_out_q;

	logic signed [DW-1:0]    ld_x;
	logic signed [DW-1:0]    ld_y;
	logic signed [DW-1:0]    sh_x;
	logic signed [DW-1:0]    sh_y;
	logic [ZACC_W-1:0]       atan_v;
	logic                    last_step;
	logic [ZACC_W-1:0]       z_rnd;
	logic [ANGLE_BITS-1:0]   angle;
	logic [ANGLE_BITS-1:0]   frac;
	logic [ANGLE_BITS:0]     frac_m;
	logic [FOLDW-1:0]        fold_t;
	logic [PRODW-1:0]        prod_f;
	logic [SHW-1:0]          shifted;
	logic [VALUE_W-1:0]      val;
	logic                    out_free;

	// difference vector scaled by 256
	assign ld_x = $signed({{(DW-DIFF_W){job_dx[DIFF_W-1]}}, job_dx}) <<< 8;
	assign ld_y = $signed({{(DW-DIFF_W){job_dy[DIFF_W-1]}}, job_dy}) <<< 8;

	assign sh_x      = x_q >>> step_q;
	assign sh_y      = y_q >>> step_q;
	assign atan_v    = atan_turn(ATAN_IDX_W'(step_q));
	assign last_step = (step_q == SW'(CORDIC_STEPS - 1));

	// round to nearest at ANGLE_BITS
	assign z_rnd = z_q + (ZACC_W'(1) << (ZACC_W - 1 - ANGLE_BITS));
	assign angle = zero_q ? '0 : z_rnd[ZACC_W-1 -: ANGLE_BITS];

	assign frac   = angle - ref_q;
	assign frac_m = (angle_mode == MODE_ACW) ? ({1'b1, {ANGLE_BITS{1'b0}}} - {1'b0, frac})
		: {1'b0, frac};

	// symmetric fold: triangle of period one turn, peak one
	always_comb begin
		fold_t = {prod_q[FOLDW-2:0], 1'b0};
		if (fold_t > (FOLDW'(1) << (ANGLE_BITS + 8))) begin
			fold_t = '0 - fold_t;
		end
		prod_f  = (angle_mode == MODE_SYM) ? {{(PRODW-FOLDW){1'b0}}, fold_t} : prod_q;
		shifted = prod_f[PRODW-1 -: SHW];
		if (zero_q) begin
			val = VALUE_CENTRE;
		end else if (shifted > SHW'(VALUE_MAX)) begin
			val = VALUE_MAX;
		end else begin
			val = shifted[VALUE_W-1:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign job_pop  = (state_q == ST_IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ref_q   <= '0;
			gain_q  <= GAIN_RESET;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						step_q  <= '0;
						state_q <= ST_ROT;
						if (job_frame) begin
							gain_q <= job_gain;
						end
					end
				end
				ST_ROT: begin
					step_q <= step_q + 1'b1;
					if (last_step) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// z holds every rotation step here
					if (frame_q) begin
						ref_q   <= angle;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			frame_q <= job_frame;
			last_q  <= job_last;
			zero_q  <= (job_dx == '0) && (job_dy == '0);
			if (ld_x < 0) begin
				x_q <= -ld_x;
				y_q <= -ld_y;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= ld_x;
				y_q <= ld_y;
				z_q <= '0;
			end
		end else if (state_q == ST_ROT) begin
			if (y_q > 0) begin
				x_q <= x_q + sh_y;
				y_q <= y_q - sh_x;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - sh_y;
				y_q <= y_q + sh_x;
				z_q <= z_q - atan_v;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= PRODW'(frac_m) * PRODW'(gain_q);
		end
		if ((state_q == ST_OUT) && out_free) begin
			value_q    <= val;
			last_out_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign value         = value_q;
	assign last_of_frame = last_out_q;

endmodule

// ----- hw/rtl/cgpg_checker.sv -----
// Port-level assertions for the cone gradient generator, bound to the top level.
module cgpg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [cgpg_pkg::VALUE_W-1:0]      value,
	input logic                              last_of_frame
);
	import cgpg_pkg::*;

	// largest reachable value: one full turn times the largest gain
	localparam logic [VALUE_W-1:0] VALUE_PEAK = 24'hFFFF00;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(last_of_frame))
		else $error("result changed while stalled");

	// gain product never exceeds its bound
	a_value_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> value <= VALUE_PEAK)
		else $error("value above reachable peak");

	// the queue fills only by taking an item
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without a transaction");

endmodule

bind cone_gradient_pixel_generator_core cgpg_checker u_cgpg_checker (.*);
